/* hw/rtl/tspr_pkg.sv */
// ----------------------------------------------------------------------------
// Timed slot pool package
// Types, widths and constants shared by the slot pool front end, command
// queue, back end and top level.
// ----------------------------------------------------------------------------
package tspr_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int QUEUE_DEPTH   = 2;

    localparam int TIME_W  = 16;
    localparam int POOL_W  = 5;
    localparam int MASK_W  = 16;
    localparam int INDEX_W = 4;

    localparam logic [POOL_W-1:0] POOL_RESET = 5'd16;

    typedef enum logic {
        OP_TICK     = 1'b0,
        OP_ACTIVATE = 1'b1
    } t_opcode;

    // One classified command: the opcode and the single time value it uses.
    typedef struct packed {
        t_opcode             op;
        logic [TIME_W-1:0]   value;
    } t_cmd;

    typedef struct packed {
        logic                granted;
        logic [INDEX_W-1:0]  slot_index;
        logic                stolen;
        logic [MASK_W-1:0]   expired_mask;
        logic [MASK_W-1:0]   busy_mask;
    } t_result;

endpackage

/* hw/rtl/timed_slot_pool_round_robin_unit.sv */
// ----------------------------------------------------------------------------
// Timed slot pool with round-robin allocation
// Top level: configuration register, front end, command queue and back end.
// ----------------------------------------------------------------------------
// The unit keeps SLOTS timed slots. An activate beat takes the first idle slot
// among the first pool_size slots, searching from a rotating pointer, or
// steals the slot at the pointer when all are busy; a tick beat counts every
// busy slot down and frees those that run out. Every input beat yields exactly
// one result beat. Input beats enter a one-beat front register and a
// two-entry command queue, so the input side keeps taking beats while the
// back end works and while a result waits to be popped. The back end
// sequencer sets the rate and takes no new command until it is idle again:
// an activate runs through load, candidate masks, search and commit, a
// tick through load and update, and an activate with pool size zero
// through load and candidate masks. A result appears in the cycle after the
// last step, and the back end loads its next command only once the result
// register is free or being popped. The pool size register resets to 16
// and must only be written while the unit is idle; writes are always accepted.
module timed_slot_pool_round_robin_unit #(
    parameter int SLOTS = tspr_pkg::SLOTS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         i_opcode,
    input  logic [tspr_pkg::TIME_W-1:0]  i_duration_ms,
    input  logic [tspr_pkg::TIME_W-1:0]  i_elapsed_ms,
    output logic                         empty,
    input  logic                         pop,
    output logic                         o_granted,
    output logic [tspr_pkg::INDEX_W-1:0] o_slot_index,
    output logic                         o_stolen,
    output logic [tspr_pkg::MASK_W-1:0]  o_expired_mask,
    output logic [tspr_pkg::MASK_W-1:0]  o_busy_mask,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tspr_pkg::POOL_W-1:0]  i_cfg_pool_size
);

    logic [tspr_pkg::POOL_W-1:0] r_pool_size;
    logic                        front_valid;
    tspr_pkg::t_cmd              front_cmd;
    logic                        queue_ready;
    logic                        queue_valid;
    tspr_pkg::t_cmd              queue_cmd;
    logic                        back_ready;
    logic                        res_valid;
    tspr_pkg::t_result           res;

    // The configuration channel never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= tspr_pkg::POOL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pool_size <= i_cfg_pool_size;
        end
    end

    tspr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_opcode      (i_opcode),
        .i_duration_ms (i_duration_ms),
        .i_elapsed_ms  (i_elapsed_ms),
        .o_cmd_valid   (front_valid),
        .o_cmd         (front_cmd),
        .i_cmd_ready   (queue_ready)
    );

    tspr_queue #(
        .DEPTH (tspr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .o_wr_ready (queue_ready),
        .i_wr_cmd   (front_cmd),
        .o_rd_valid (queue_valid),
        .o_rd_cmd   (queue_cmd),
        .i_rd_ready (back_ready)
    );

    tspr_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_ready (back_ready),
        .i_pool_size (r_pool_size),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_pop   (pop)
    );

    assign empty          = !res_valid;
    assign o_granted      = res.granted;
    assign o_slot_index   = res.slot_index;
    assign o_stolen       = res.stolen;
    assign o_expired_mask = res.expired_mask;
    assign o_busy_mask    = res.busy_mask;

`ifndef SYNTHESIS
    // A slot freed by a tick cannot still be busy after it.
    a_expired_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_expired_mask & o_busy_mask) == '0))
        else $error("expired slot still reported busy");

    // An activate never reports expirations.
    a_grant_no_expire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_granted) |-> (o_expired_mask == '0))
        else $error("granted result carries expired slots");

    // A steal is always a grant.
    a_steal_is_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_stolen) |-> o_granted)
        else $error("stolen without grant");

    // A result that is not popped stays in place.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_busy_mask) && $stable(o_slot_index)))
        else $error("waiting result changed or vanished");
`endif

endmodule

/* hw/rtl/tspr_front.sv */
// ----------------------------------------------------------------------------
// Timed slot pool front end
// Accepts input beats, classifies them and hands commands to the queue.
// ----------------------------------------------------------------------------
module tspr_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic                        i_opcode,
    input  logic [tspr_pkg::TIME_W-1:0] i_duration_ms,
    input  logic [tspr_pkg::TIME_W-1:0] i_elapsed_ms,
    output logic                        o_cmd_valid,
    output tspr_pkg::t_cmd              o_cmd,
    input  logic                        i_cmd_ready
);

    logic           r_valid;
    logic           n_valid;
    tspr_pkg::t_cmd r_cmd;
    tspr_pkg::t_cmd n_cmd;
    logic           accept;

    assign o_full      = r_valid && !i_cmd_ready;
    assign accept      = i_push && !o_full;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Only the time value that the opcode uses travels on.
    always_comb begin
        n_cmd.op    = tspr_pkg::t_opcode'(i_opcode);
        n_cmd.value = (n_cmd.op == tspr_pkg::OP_ACTIVATE) ? i_duration_ms : i_elapsed_ms;
        n_valid     = accept ? 1'b1 : (i_cmd_ready ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

/* hw/rtl/tspr_queue.sv */
// ----------------------------------------------------------------------------
// Timed slot pool command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tspr_queue #(
    parameter int DEPTH = tspr_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  tspr_pkg::t_cmd i_wr_cmd,
    output logic           o_rd_valid,
    output tspr_pkg::t_cmd o_rd_cmd,
    input  logic           i_rd_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    tspr_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_wr;
    logic             do_rd;

    assign o_wr_ready = (r_count != CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_cmd   = r_mem[r_rd_ptr];
    assign do_wr      = i_wr_valid && o_wr_ready;
    assign do_rd      = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule

/* hw/rtl/tspr_back.sv */
// ----------------------------------------------------------------------------
// Timed slot pool back end
// Holds the slot timers, runs the round-robin search and the tick update,
// and keeps the result register.
// ----------------------------------------------------------------------------
module tspr_back #(
    parameter int SLOTS = tspr_pkg::SLOTS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  tspr_pkg::t_cmd              i_cmd,
    output logic                        o_cmd_ready,
    input  logic [tspr_pkg::POOL_W-1:0] i_pool_size,
    output logic                        o_res_valid,
    output tspr_pkg::t_result           o_res,
    input  logic                        i_res_pop
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > tspr_pkg::POOL_W) ? CNT_W : tspr_pkg::POOL_W;
    localparam int MW    = (SLOTS > tspr_pkg::MASK_W) ? SLOTS : tspr_pkg::MASK_W;
    localparam int PW    = (IDX_W > tspr_pkg::INDEX_W) ? IDX_W : tspr_pkg::INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_PREP,
        S_PICK,
        S_COMMIT
    } t_state;

    t_state                    r_state,   n_state;
    tspr_pkg::t_cmd            r_cmd,     n_cmd;
    logic [tspr_pkg::TIME_W-1:0] r_time [SLOTS];
    logic [tspr_pkg::TIME_W-1:0] n_time [SLOTS];
    logic [SLOTS-1:0]          r_busy,    n_busy;
    logic [IDX_W-1:0]          r_ptr,     n_ptr;
    logic [CNT_W-1:0]          r_n,       n_n;
    logic [IDX_W-1:0]          r_start,   n_start;
    logic [SLOTS-1:0]          r_hi,      n_hi;
    logic [SLOTS-1:0]          r_lo,      n_lo;
    logic [IDX_W-1:0]          r_pick,    n_pick;
    logic                      r_found,   n_found;
    logic                      r_res_valid, n_res_valid;
    tspr_pkg::t_result         r_res,     n_res;

    logic                      out_free;
    logic [CMP_W-1:0]          pool_ext;
    logic [CMP_W-1:0]          pool_eff;
    logic [SLOTS-1:0]          hi_first;
    logic [SLOTS-1:0]          lo_first;
    logic [CNT_W-1:0]          pick_next;
    logic [MW-1:0]             busy_pad;
    logic [MW-1:0]             exp_pad;
    logic [SLOTS-1:0]          expired;
    logic [PW-1:0]             pick_pad;

    function automatic logic [IDX_W-1:0] f_encode(input logic [SLOTS-1:0] onehot);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (onehot[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

    assign out_free    = !r_res_valid || i_res_pop;
    assign o_cmd_ready = (r_state == S_IDLE) && out_free;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_time      = r_time;
        n_busy      = r_busy;
        n_ptr       = r_ptr;
        n_n         = r_n;
        n_start     = r_start;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_pick      = r_pick;
        n_found     = r_found;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_res_pop;
        expired     = '0;

        // Effective pool size saturates at the number of slots.
        pool_ext = CMP_W'(i_pool_size);
        pool_eff = (pool_ext > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : pool_ext;

        // Lowest set bit of each candidate mask.
        hi_first  = r_hi & (~r_hi + 1'b1);
        lo_first  = r_lo & (~r_lo + 1'b1);
        pick_next = CNT_W'(r_pick) + 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    n_cmd   = i_cmd;
                    n_state = (i_cmd.op == tspr_pkg::OP_ACTIVATE) ? S_PREP : S_TICK;
                end
            end
            S_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (r_busy[i]) begin
                        if (r_time[i] <= r_cmd.value) begin
                            n_busy[i]  = 1'b0;
                            n_time[i]  = '0;
                            expired[i] = 1'b1;
                        end else begin
                            n_time[i] = r_time[i] - r_cmd.value;
                        end
                    end
                end
                n_res.granted    = 1'b0;
                n_res.slot_index = '0;
                n_res.stolen     = 1'b0;
                n_res_valid      = 1'b1;
                n_state          = S_IDLE;
            end
            S_PREP: begin
                n_n     = CNT_W'(pool_eff);
                n_start = (CNT_W'(r_ptr) < n_n) ? r_ptr : '0;
                for (int i = 0; i < SLOTS; i++) begin
                    n_lo[i] = !r_busy[i] && (CNT_W'(i) < n_n);
                    n_hi[i] = n_lo[i] && (IDX_W'(i) >= n_start);
                end
                if (n_n == '0) begin
                    n_res.granted    = 1'b0;
                    n_res.slot_index = '0;
                    n_res.stolen     = 1'b0;
                    n_res_valid      = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                // Search wraps: slots at or past the start first, then from zero.
                priority if (r_hi != '0) begin
                    n_pick  = f_encode(hi_first);
                    n_found = 1'b1;
                end else if (r_lo != '0) begin
                    n_pick  = f_encode(lo_first);
                    n_found = 1'b1;
                end else begin
                    n_pick  = r_start;
                    n_found = 1'b0;
                end
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                n_busy[r_pick]   = 1'b1;
                n_time[r_pick]   = r_cmd.value;
                n_ptr            = (pick_next >= r_n) ? '0 : IDX_W'(pick_next);
                n_res.granted    = 1'b1;
                n_res.slot_index = pick_pad[tspr_pkg::INDEX_W-1:0];
                n_res.stolen     = !r_found;
                n_res_valid      = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        busy_pad = MW'(n_busy);
        exp_pad  = MW'(expired);
        if (r_state == S_TICK || r_state == S_PREP || r_state == S_COMMIT) begin
            n_res.busy_mask    = busy_pad[tspr_pkg::MASK_W-1:0];
            n_res.expired_mask = exp_pad[tspr_pkg::MASK_W-1:0];
        end
    end

    assign pick_pad = PW'(r_pick);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= '0;
            r_ptr       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_ptr       <= n_ptr;
            r_res_valid <= n_res_valid;
        end
        r_cmd   <= n_cmd;
        r_time  <= n_time;
        r_n     <= n_n;
        r_start <= n_start;
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_pick  <= n_pick;
        r_found <= n_found;
        r_res   <= n_res;
    end

endmodule
